@@ rtl/ptt_pkg.sv @@
// Package for the pixel threshold trim tuner: constants, beat types and encode helper.
`timescale 1ns / 1ps

package ptt_pkg;

  localparam int COLUMNS = 64;
  localparam int ROWS    = 64;
  localparam int PIXELS  = COLUMNS * ROWS;
  localparam int ADDR_W  = (PIXELS > 1) ? $clog2(PIXELS) : 1;

  localparam int TRIM_W  = 5;
  localparam int STEP_W  = 5;
  localparam int FB_W    = 8;
  localparam int ITER_W  = 8;

  localparam logic [ITER_W-1:0] ITER_MAX = '1;

  localparam logic [1:0] ACT_INIT     = 2'd0;
  localparam logic [1:0] ACT_FEEDBACK = 2'd1;
  localparam logic [1:0] ACT_END_ITER = 2'd2;

  localparam logic [1:0] REG_STEP_START = 2'd0;
  localparam logic [1:0] REG_MIN_VALUE  = 2'd1;
  localparam logic [1:0] REG_MAX_VALUE  = 2'd2;

  localparam logic [STEP_W-1:0] STEP_START_RST = 5'd8;
  localparam logic [TRIM_W-1:0] MIN_VALUE_RST  = 5'd16;
  localparam logic [TRIM_W-1:0] MAX_VALUE_RST  = 5'd31;

  typedef struct packed {
    logic [1:0]             action;
    logic [5:0]             column;
    logic [5:0]             pixel_row;
    logic signed [FB_W-1:0] feedback_sign;
  } in_beat_t;

  typedef struct packed {
    logic              trim_sign;
    logic [3:0]        trim_dac;
    logic [TRIM_W-1:0] trim_value;
    logic [STEP_W-1:0] current_step;
    logic              done_res;
    logic [ITER_W-1:0] iteration;
  } out_beat_t;

  // sign/TDAC encoding: {sign, dac}
  function automatic logic [4:0] trim_encode(input logic [TRIM_W-1:0] v);
    logic [4:0] enc;
    if (v[4]) begin
      enc = {1'b0, v[3:0]};
    end else begin
      enc = {1'b1, ~v[3:0]};
    end
    return enc;
  endfunction

endpackage

@@ rtl/ptt_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/ptt_trim_calc.sv @@
// Trim update datapath: old value minus step times feedback, clamped to 0..max.
`timescale 1ns / 1ps

module ptt_trim_calc (
  input  logic [ptt_pkg::TRIM_W-1:0]      old_val,
  input  logic [ptt_pkg::STEP_W-1:0]      step,
  input  logic signed [ptt_pkg::FB_W-1:0] feedback,
  input  logic [ptt_pkg::TRIM_W-1:0]      max_val,
  output logic [ptt_pkg::TRIM_W-1:0]      new_val
);
  import ptt_pkg::*;

  logic signed [STEP_W+FB_W:0]   prod;
  logic signed [STEP_W+FB_W+1:0] prod_x;
  logic signed [STEP_W+FB_W+1:0] old_x;
  logic signed [STEP_W+FB_W+1:0] max_x;
  logic signed [STEP_W+FB_W+1:0] diff;

  always_comb begin
    prod   = $signed({1'b0, step}) * feedback;
    prod_x = {prod[STEP_W+FB_W], prod};
    old_x  = $signed({{(STEP_W+FB_W+2-TRIM_W){1'b0}}, old_val});
    max_x  = $signed({{(STEP_W+FB_W+2-TRIM_W){1'b0}}, max_val});
    diff   = old_x - prod_x;
    if (diff[STEP_W+FB_W+1]) begin
      new_val = '0;
    end else if (diff > max_x) begin
      new_val = max_val;
    end else begin
      new_val = diff[TRIM_W-1:0];
    end
  end

endmodule

@@ rtl/pixel_threshold_trim_tuner_unit.sv @@
// Pixel threshold trim tuner: trim store, tuning status and configuration port.
// An accepted input beat is registered into the update stage (RAM read, s1 registers); its
// result is then loaded into the output register, which raises out_valid.
// Throughput: one beat per cycle, including read-modify-write of the same pixel back to back;
// a stalled result beat holds the input off.
// The trim store RAM is not cleared; an entry is undefined until an ACT_INIT beat writes it.
// Reset (rst_n low, synchronous) empties the pipeline and loads registers to 8/16/31,
// step to 8, previous step, done flag and iteration count to 0.
`timescale 1ns / 1ps

module pixel_threshold_trim_tuner_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ptt_pkg::in_beat_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ptt_pkg::out_beat_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import ptt_pkg::*;

  logic [STEP_W-1:0] step_start_r;
  logic [TRIM_W-1:0] min_value_r;
  logic [TRIM_W-1:0] max_value_r;

  logic [STEP_W-1:0] step_now_r, step_now_nxt;
  logic [STEP_W-1:0] step_before_r, step_before_nxt;
  logic              done_r, done_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;

  logic                   s1_v_r;
  logic [1:0]             s1_action_r;
  logic                   s1_inside_r;
  logic [ADDR_W-1:0]      s1_addr_r;
  logic signed [FB_W-1:0] s1_fb_r;
  logic                   fwd_hit_r;
  logic [TRIM_W-1:0]      fwd_data_r;

  logic      out_v_r;
  out_beat_t out_data_r, out_data_nxt;

  logic              in_acc, out_load, cfg_wr;
  logic [1:0]        cfg_idx;
  logic              in_inside;
  logic [ADDR_W-1:0] in_addr;
  logic              ram_we;
  logic [TRIM_W-1:0] ram_wdata;
  logic [TRIM_W-1:0] ram_rdata;
  logic [TRIM_W-1:0] old_val;
  logic [TRIM_W-1:0] calc_val;
  logic [TRIM_W-1:0] trim_val;
  logic              with_trim;
  logic [4:0]        enc;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    case (cfg_idx)
      REG_STEP_START: prdata = {{(32-STEP_W){1'b0}}, step_start_r};
      REG_MIN_VALUE:  prdata = {{(32-TRIM_W){1'b0}}, min_value_r};
      REG_MAX_VALUE:  prdata = {{(32-TRIM_W){1'b0}}, max_value_r};
      default:        prdata = '0;
    endcase
  end

  assign out_load  = s1_v_r & (~out_v_r | ~out_stall);
  assign in_stall  = s1_v_r & ~out_load;
  assign in_acc    = in_valid & ~in_stall;
  assign in_inside = (int'(in_data.column) < COLUMNS) && (int'(in_data.pixel_row) < ROWS);
  assign in_addr   = ADDR_W'(int'(in_data.pixel_row) * COLUMNS + int'(in_data.column));

  ptt_ram #(
    .WIDTH (TRIM_W),
    .DEPTH (PIXELS)
  ) u_trim_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr_r),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  // write landing on the same edge as the read returns stale data
  assign old_val = fwd_hit_r ? fwd_data_r : ram_rdata;

  ptt_trim_calc u_calc (
    .old_val  (old_val),
    .step     (step_now_r),
    .feedback (s1_fb_r),
    .max_val  (max_value_r),
    .new_val  (calc_val)
  );

  always_comb begin
    step_now_nxt    = step_now_r;
    step_before_nxt = step_before_r;
    done_nxt        = done_r;
    iter_nxt        = iter_r;
    ram_we          = 1'b0;
    ram_wdata       = calc_val;
    trim_val        = '0;
    with_trim       = 1'b0;
    case (s1_action_r)
      ACT_INIT: begin
        if (s1_inside_r) begin
          ram_we    = out_load;
          ram_wdata = min_value_r;
          trim_val  = min_value_r;
          with_trim = 1'b1;
          done_nxt  = 1'b0;
          iter_nxt  = '0;
        end
      end
      ACT_FEEDBACK: begin
        if (s1_inside_r) begin
          ram_we    = out_load;
          trim_val  = calc_val;
          with_trim = 1'b1;
        end
      end
      ACT_END_ITER: begin
        if (step_now_r == STEP_W'(1) && step_before_r == STEP_W'(1)) begin
          done_nxt = 1'b1;
        end
        step_before_nxt = step_now_r;
        step_now_nxt    = step_now_r >> 1;
        if (step_now_nxt == '0) begin
          step_now_nxt = STEP_W'(1);
        end
        if (iter_r != ITER_MAX) begin
          iter_nxt = iter_r + ITER_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    enc                       = trim_encode(trim_val);
    out_data_nxt.trim_sign    = with_trim & enc[4];
    out_data_nxt.trim_dac     = with_trim ? enc[3:0] : 4'd0;
    out_data_nxt.trim_value   = trim_val;
    out_data_nxt.current_step = step_now_nxt;
    out_data_nxt.done_res     = done_nxt;
    out_data_nxt.iteration    = iter_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_start_r  <= STEP_START_RST;
      min_value_r   <= MIN_VALUE_RST;
      max_value_r   <= MAX_VALUE_RST;
      step_now_r    <= STEP_START_RST;
      step_before_r <= '0;
      done_r        <= 1'b0;
      iter_r        <= '0;
      s1_v_r        <= 1'b0;
      out_v_r       <= 1'b0;
      fwd_hit_r     <= 1'b0;
    end else begin
      if (out_load) begin
        step_now_r    <= step_now_nxt;
        step_before_r <= step_before_nxt;
        done_r        <= done_nxt;
        iter_r        <= iter_nxt;
      end
      if (cfg_wr) begin
        case (cfg_idx)
          REG_STEP_START: begin
            step_start_r <= pwdata[STEP_W-1:0];
            step_now_r   <= pwdata[STEP_W-1:0];
          end
          REG_MIN_VALUE: min_value_r <= pwdata[TRIM_W-1:0];
          REG_MAX_VALUE: max_value_r <= pwdata[TRIM_W-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        s1_v_r    <= 1'b1;
        fwd_hit_r <= ram_we && (s1_addr_r == in_addr);
      end else if (out_load) begin
        s1_v_r <= 1'b0;
      end
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_action_r <= in_data.action;
      s1_inside_r <= in_inside;
      s1_addr_r   <= in_addr;
      s1_fb_r     <= in_data.feedback_sign;
      fwd_data_r  <= ram_wdata;
    end
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

  a_stall_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_v_r)
    else $error("input stalled with empty update stage");

  a_write_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (out_load && s1_inside_r))
    else $error("trim store written outside an update");

  a_step_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && s1_action_r == ACT_END_ITER && !cfg_wr) |=> (step_now_r != '0))
    else $error("step fell to zero after end of iteration");

  a_out_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && s1_action_r == ACT_END_ITER && done_r) |=> out_data_r.done_res)
    else $error("done flag dropped at end of iteration");

endmodule
